// ===== rtl/pulse_width_byte_transmitter_defines.svh =====
// Assertion macros for the pulse width byte transmitter
`ifndef PULSE_WIDTH_BYTE_TRANSMITTER_DEFINES_SVH
`define PULSE_WIDTH_BYTE_TRANSMITTER_DEFINES_SVH

// same-cycle implication
`define PWBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwbt assertion failed");

// next-cycle implication
`define PWBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwbt assertion failed");

`endif

// ===== rtl/pwbt_pkg.sv =====
// Shared types and constants for the pulse width byte transmitter
package pwbt_pkg;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_START_HIGH = 3'd1,
      PH_START_LOW  = 3'd2,
      PH_BIT_HIGH   = 3'd3,
      PH_BIT_LOW    = 3'd4
   } phase_type;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HIGH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG       = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] START_HIGH_RESET = 16'd16;
   localparam logic [CSR_DATA_WIDTH-1:0] SHORT_RESET      = 16'd4;
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_RESET       = 16'd8;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
      logic frame_done;
   } result_type;

endpackage

// ===== rtl/pwbt_front.sv =====
// Front stage: accepts request transfers and classifies them as tick or send
module pwbt_front #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [DATA_BITS-1:0] req_byte_value,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic                 push_send,
   output logic [DATA_BITS-1:0] push_data
);
   import pwbt_pkg::*;

   logic                 valid_ff;
   logic                 send_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic                 send_in;
   logic [DATA_BITS-1:0] data_in;

   assign req_ready = !valid_ff || push_ready;

   always_comb begin
      send_in = (req_type == REQ_SEND);
      data_in = send_in ? req_byte_value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         send_ff <= send_in;
         data_ff <= data_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_send  = send_ff;
   assign push_data  = data_ff;

endmodule

// ===== rtl/pwbt_queue.sv =====
// Short command queue between front and back
module pwbt_queue #(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import pwbt_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   push_fire;
   logic                   pop_fire;

   assign push_ready = (count_ff != COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pwbt_engine.sv =====
// Back end: frame sequencer, timing registers and result register
module pwbt_engine #(
   parameter int DATA_BITS   = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [pwbt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pwbt_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  logic                                   cmd_valid,
   output logic                                   cmd_ready,
   input  logic                                   cmd_send,
   input  logic [DATA_BITS-1:0]                   cmd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pwbt_pkg::result_type                   rsp_result
);
   import pwbt_pkg::*;

   localparam int BITS_WIDTH = $clog2(DATA_BITS + 1);
   localparam int EXT_WIDTH  =
      ((COUNT_WIDTH > CSR_DATA_WIDTH) ? COUNT_WIDTH : CSR_DATA_WIDTH) + 1;

   logic [CSR_DATA_WIDTH-1:0] start_high_ff;
   logic [CSR_DATA_WIDTH-1:0] short_ff;
   logic [CSR_DATA_WIDTH-1:0] long_ff;

   phase_type                 phase_ff;
   phase_type                 phase_in;
   logic [COUNT_WIDTH-1:0]    tick_ff;
   logic [COUNT_WIDTH-1:0]    tick_in;
   logic [DATA_BITS-1:0]      shift_ff;
   logic [DATA_BITS-1:0]      shift_in;
   logic [BITS_WIDTH-1:0]     bits_ff;
   logic [BITS_WIDTH-1:0]     bits_in;
   logic                      rsp_valid_ff;
   result_type                result_ff;
   result_type                result_in;
   logic                      rejected_in;
   logic                      done_in;

   logic                      cmd_fire;
   logic                      bit_one;
   logic [CSR_DATA_WIDTH-1:0] dur;
   logic [EXT_WIDTH-1:0]      dur_ext;
   logic [EXT_WIDTH-1:0]      cap;
   logic [EXT_WIDTH-1:0]      eff_dur;
   logic [EXT_WIDTH-1:0]      next_count;
   logic                      expired;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign cmd_fire  = cmd_valid && cmd_ready;

   // phase duration, zero acts as one, capped at the counter range
   always_comb begin
      bit_one = shift_ff[DATA_BITS-1];
      unique case (phase_ff)
         PH_START_HIGH: dur = start_high_ff;
         PH_START_LOW:  dur = short_ff;
         PH_BIT_HIGH:   dur = bit_one ? long_ff : short_ff;
         PH_BIT_LOW,
         PH_IDLE:       dur = bit_one ? short_ff : long_ff;
         default:       dur = bit_one ? short_ff : long_ff;
      endcase
      dur_ext    = EXT_WIDTH'(dur);
      cap        = EXT_WIDTH'(1) << COUNT_WIDTH;
      eff_dur    = (dur == '0) ? EXT_WIDTH'(1) : ((dur_ext > cap) ? cap : dur_ext);
      next_count = EXT_WIDTH'(tick_ff) + EXT_WIDTH'(1);
      expired    = (next_count >= eff_dur);
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      shift_in    = shift_ff;
      bits_in     = bits_ff;
      rejected_in = 1'b0;
      done_in     = 1'b0;
      if (cmd_send) begin
         if (phase_ff != PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            shift_in = cmd_data;
            tick_in  = '0;
            bits_in  = '0;
            phase_in = PH_START_HIGH;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (expired) begin
            tick_in = '0;
            unique case (phase_ff)
               PH_START_HIGH: phase_in = PH_START_LOW;
               PH_START_LOW: begin
                  phase_in = PH_BIT_HIGH;
                  bits_in  = BITS_WIDTH'(DATA_BITS);
               end
               PH_BIT_HIGH:   phase_in = PH_BIT_LOW;
               default: begin
                  shift_in = shift_ff << 1;
                  if (bits_ff <= BITS_WIDTH'(1)) begin
                     bits_in  = '0;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     bits_in  = bits_ff - 1'b1;
                     phase_in = PH_BIT_HIGH;
                  end
               end
            endcase
         end else begin
            tick_in = next_count[COUNT_WIDTH-1:0];
         end
      end
   end

   // result fields
   always_comb begin
      result_in.line_level = (phase_in == PH_START_HIGH) || (phase_in == PH_BIT_HIGH);
      result_in.busy_res   = (phase_in != PH_IDLE);
      result_in.rejected   = rejected_in;
      result_in.frame_done = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_high_ff <= START_HIGH_RESET;
         short_ff      <= SHORT_RESET;
         long_ff       <= LONG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_HIGH: start_high_ff <= csr_data;
            CSR_SHORT:      short_ff      <= csr_data;
            CSR_LONG:       long_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         shift_ff     <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_fire) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            bits_ff  <= bits_in;
         end
         if (cmd_ready) begin
            rsp_valid_ff <= cmd_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/pulse_width_byte_transmitter.sv =====
// Top level of the pulse width byte transmitter
// A request passes through the front stage register, the queue and the result register before its result is presented.
// Throughput: one item per cycle while rsp_ready does not hold back the result.
// Reset clears the front stage, queue and sequencer to idle and loads the
// timing registers with 16, 4 and 8 ticks; no clearing pass is needed.
module pulse_width_byte_transmitter #(
   parameter int DATA_BITS   = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [DATA_BITS-1:0]                 req_byte_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_line_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_rejected,
   output logic                                 rsp_frame_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwbt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pwbt_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import pwbt_pkg::*;

   localparam int CMD_WIDTH = DATA_BITS + 1;

   logic                 push_valid;
   logic                 push_ready;
   logic                 push_send;
   logic [DATA_BITS-1:0] push_data;
   logic                 cmd_valid;
   logic                 cmd_ready;
   logic [CMD_WIDTH-1:0] cmd_word;
   result_type           result;

   assign csr_ready = 1'b1;

   pwbt_front #(
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_byte_value (req_byte_value),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_send      (push_send),
      .push_data      (push_data)
   );

   pwbt_queue #(
      .WIDTH (CMD_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_send, push_data}),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd_word)
   );

   pwbt_engine #(
      .DATA_BITS   (DATA_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_send   (cmd_word[CMD_WIDTH-1]),
      .cmd_data   (cmd_word[DATA_BITS-1:0]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_line_level = result.line_level;
   assign rsp_busy_res   = result.busy_res;
   assign rsp_rejected   = result.rejected;
   assign rsp_frame_done = result.frame_done;

endmodule

// ===== rtl/pwbt_checker.sv =====
// Port-level assertion checker for the pulse width byte transmitter, with bind
`include "pulse_width_byte_transmitter_defines.svh"

module pwbt_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_line_level,
   input logic rsp_busy_res,
   input logic rsp_rejected,
   input logic rsp_frame_done
);

   `PWBT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_line_level, rsp_busy_res, rsp_rejected, rsp_frame_done}))
   `PWBT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `PWBT_ASSERT_IMP(a_reject_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res && !rsp_frame_done)
   `PWBT_ASSERT_IMP(a_done_idle, clock, reset, rsp_valid && rsp_frame_done, !rsp_busy_res && !rsp_line_level)
   `PWBT_ASSERT_IMP(a_high_busy, clock, reset, rsp_valid && rsp_line_level, rsp_busy_res)

endmodule

bind pulse_width_byte_transmitter pwbt_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_rejected   (rsp_rejected),
   .rsp_frame_done (rsp_frame_done)
);
